### sv/sup_pkg.sv
package sup_pkg;

    localparam int MAX_LEN_DEF    = 65535;
    localparam int VALUE_BITS_DEF = 64;

    localparam int CH_W    = 8;
    localparam int BASE_W  = 6;
    localparam int DIG_W   = 6;
    localparam int END_W   = 16;
    localparam int OUT_W   = 64;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
    localparam logic [BASE_W-1:0] BASE_ONE   = BASE_W'(1);
    localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
    localparam logic [DIG_W-1:0]  NOT_DIGIT  = DIG_W'(36);

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_SP    = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    // one classified character as it travels from front to back
    typedef struct packed {
        logic             space;
        logic             plus;
        logic             minus;
        logic             zero;
        logic             hex_x;
        logic [DIG_W-1:0] digit;
        logic             last;
    } t_cls;

    function automatic logic [DIG_W-1:0] digit_of(logic [CH_W-1:0] c);
        logic [DIG_W-1:0] d;
        d = NOT_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIG_W'(c - CH_ZERO);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = DIG_W'(c - CH_UA) + DIG_W'(10);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = DIG_W'(c - CH_LA) + DIG_W'(10);
        end
        return d;
    endfunction

endpackage

### sv/sup_front.sv
module sup_front (
    input  logic [sup_pkg::CH_W-1:0] i_ch,
    input  logic                     i_last,
    output sup_pkg::t_cls            o_cls
);

    always_comb begin
        o_cls.space = (i_ch == sup_pkg::CH_SP)
                   || (i_ch >= sup_pkg::CH_TAB && i_ch <= sup_pkg::CH_CR);
        o_cls.plus  = (i_ch == sup_pkg::CH_PLUS);
        o_cls.minus = (i_ch == sup_pkg::CH_MINUS);
        o_cls.zero  = (i_ch == sup_pkg::CH_ZERO);
        o_cls.hex_x = (i_ch == sup_pkg::CH_LX) || (i_ch == sup_pkg::CH_UX);
        o_cls.digit = sup_pkg::digit_of(i_ch);
        o_cls.last  = i_last;
    end

endmodule

### sv/sup_queue.sv
module sup_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sup_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sup_pkg::t_cls o_data
);

    sup_pkg::t_cls                 r_mem [sup_pkg::QDEPTH];
    logic [sup_pkg::QPTR_W-1:0]    r_wr, n_wr;
    logic [sup_pkg::QPTR_W-1:0]    r_rd, n_rd;
    logic [sup_pkg::QCNT_W-1:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == sup_pkg::QCNT_W'(sup_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### sv/sup_back.sv
module sup_back #(
    parameter int MAX_LEN    = sup_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = sup_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [sup_pkg::BASE_W-1:0] i_base,
    input  logic                       i_valid,
    input  sup_pkg::t_cls              i_cls,
    output logic                       o_pop,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [VALUE_BITS-1:0]      o_acc,
    output logic                       o_neg,
    output logic [sup_pkg::END_W-1:0]  o_end,
    output logic                       o_ovf,
    output logic                       o_conv
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int PRW = VALUE_BITS + sup_pkg::BASE_W + 1;

    sup_pkg::t_phase              r_ph, n_ph;
    logic [VALUE_BITS-1:0]        r_acc, n_acc;
    logic [PW-1:0]                r_pos, n_pos;
    logic [sup_pkg::END_W-1:0]    r_endp, n_endp;
    logic                         r_neg, n_neg;
    logic                         r_seen, n_seen;
    logic [sup_pkg::BASE_W-1:0]   r_wb, n_wb;
    logic                         r_ovf, n_ovf;

    logic                         r_out_valid;
    logic [VALUE_BITS-1:0]        r_out_acc;
    logic                         r_out_neg;
    logic [sup_pkg::END_W-1:0]    r_out_end;
    logic                         r_out_ovf;
    logic                         r_out_conv;

    logic [PRW-1:0]               prod;
    logic                         feed_on;

    // a non-last item needs no output slot
    assign o_pop = i_valid && (!i_cls.last || !r_out_valid || i_out_ready);

    always_comb begin
        n_ph   = r_ph;
        n_acc  = r_acc;
        n_pos  = r_pos;
        n_endp = r_endp;
        n_neg  = r_neg;
        n_seen = r_seen;
        n_wb   = r_wb;
        n_ovf  = r_ovf;
        prod   = '0;
        feed_on = 1'b1;

        if (r_pos == '0) begin
            n_wb = i_base;
            if (i_base == sup_pkg::BASE_ONE || i_base > sup_pkg::BASE_MAX) begin
                n_acc  = '0;
                n_endp = '0;
                n_seen = 1'b0;
                n_neg  = 1'b0;
                n_ovf  = 1'b0;
                n_ph   = sup_pkg::PH_DONE;
            end
        end

        if (r_pos < PW'(MAX_LEN)) begin
            n_pos = r_pos + 1'b1;
        end else begin
            n_ph    = sup_pkg::PH_DONE;
            feed_on = 1'b0;
        end

        if (feed_on && n_ph != sup_pkg::PH_DONE) begin
            // phases fall through within one character, as in the scheme
            if (n_ph == sup_pkg::PH_SKIP) begin
                if (i_cls.space) begin
                    n_endp  = n_endp + 1'b1;
                    feed_on = 1'b0;
                end else if (i_cls.plus || i_cls.minus) begin
                    n_neg   = i_cls.minus;
                    n_endp  = n_endp + 1'b1;
                    n_ph    = sup_pkg::PH_SIGN;
                    feed_on = 1'b0;
                end else begin
                    n_ph = sup_pkg::PH_SIGN;
                end
            end
            if (feed_on && n_ph == sup_pkg::PH_SIGN) begin
                if (i_cls.zero) begin
                    n_endp  = n_endp + 1'b1;
                    n_seen  = 1'b1;
                    n_ph    = sup_pkg::PH_ZERO;
                    feed_on = 1'b0;
                end else begin
                    if (n_wb == sup_pkg::BASE_AUTO) begin
                        n_wb = sup_pkg::BASE_DEC;
                    end
                    n_ph = sup_pkg::PH_DIGITS;
                end
            end
            if (feed_on && n_ph == sup_pkg::PH_ZERO) begin
                if (i_cls.hex_x) begin
                    feed_on = 1'b0;
                    if (n_wb != sup_pkg::BASE_AUTO && n_wb != sup_pkg::BASE_HEX) begin
                        n_acc  = '0;
                        n_endp = '0;
                        n_seen = 1'b0;
                        n_neg  = 1'b0;
                        n_ovf  = 1'b0;
                        n_ph   = sup_pkg::PH_DONE;
                    end else begin
                        n_wb   = sup_pkg::BASE_HEX;
                        n_seen = 1'b0;
                        n_endp = n_endp + 1'b1;
                        n_ph   = sup_pkg::PH_DIGITS;
                    end
                end else begin
                    if (n_wb == sup_pkg::BASE_AUTO) begin
                        n_wb = sup_pkg::BASE_OCT;
                    end
                    n_ph = sup_pkg::PH_DIGITS;
                end
            end
            if (feed_on) begin
                prod = PRW'(n_acc) * PRW'(n_wb) + PRW'(i_cls.digit);
                if (n_wb < sup_pkg::BASE_W'(2) || i_cls.digit >= n_wb) begin
                    n_ph = sup_pkg::PH_DONE;
                end else if (|prod[PRW-1:VALUE_BITS]) begin
                    n_ovf  = 1'b1;
                    n_acc  = '1;
                    n_seen = 1'b1;
                    n_ph   = sup_pkg::PH_DONE;
                end else begin
                    n_acc  = prod[VALUE_BITS-1:0];
                    n_seen = 1'b1;
                    n_endp = n_endp + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= sup_pkg::PH_SKIP;
            r_acc  <= '0;
            r_pos  <= '0;
            r_endp <= '0;
            r_neg  <= 1'b0;
            r_seen <= 1'b0;
            r_wb   <= '0;
            r_ovf  <= 1'b0;
        end else if (o_pop) begin
            if (i_cls.last) begin
                r_ph   <= sup_pkg::PH_SKIP;
                r_acc  <= '0;
                r_pos  <= '0;
                r_endp <= '0;
                r_neg  <= 1'b0;
                r_seen <= 1'b0;
                r_wb   <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_ph   <= n_ph;
                r_acc  <= n_acc;
                r_pos  <= n_pos;
                r_endp <= n_endp;
                r_neg  <= n_neg;
                r_seen <= n_seen;
                r_wb   <= n_wb;
                r_ovf  <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_cls.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cls.last) begin
            r_out_acc  <= n_acc;
            r_out_neg  <= n_neg && n_seen && !n_ovf;
            r_out_end  <= n_endp;
            r_out_ovf  <= n_ovf;
            r_out_conv <= n_seen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_acc       = r_out_acc;
    assign o_neg       = r_out_neg;
    assign o_end       = r_out_end;
    assign o_ovf       = r_out_ovf;
    assign o_conv      = r_out_conv;

endmodule

### sv/string_to_unsigned_parser.sv
// Channel      Dir  Handshake                      Payload
// s_axis       in   s_axis_tvalid / s_axis_tready  tdata: ch[7:0]; tlast: last
// m_axis       out  m_axis_tvalid / m_axis_tready  tdata: value, end_offset, overflow, converted
// cfg          in   i_cfg_we                       i_cfg_wdata: base
//
// One character per cycle sustained while the result output is not held off; the loop
// through the accumulator multiply-add by the base sets that rate. The last character
// of a string passes through the queue, then its result through the output register.
// A 4-item queue decouples classification from the parser, so input keeps
// flowing while a result waits. Reset is synchronous.
module string_to_unsigned_parser #(
    parameter int MAX_LEN    = sup_pkg::MAX_LEN_DEF,
    parameter int VALUE_BITS = sup_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // [63:0] value, [79:64] end_offset,
                                        // [80] overflow, [81] converted, rest 0
);

    logic [sup_pkg::BASE_W-1:0]  r_base;
    sup_pkg::t_cls               front_cls;
    sup_pkg::t_cls               q_cls;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic                        push;
    logic [VALUE_BITS-1:0]       out_acc;
    logic [VALUE_BITS-1:0]       out_val;
    logic                        out_neg;
    logic [sup_pkg::END_W-1:0]   out_end;
    logic                        out_ovf;
    logic                        out_conv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= sup_pkg::BASE_RESET;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    sup_front u_front (
        .i_ch   (s_axis_tdata),
        .i_last (s_axis_tlast),
        .o_cls  (front_cls)
    );

    sup_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cls)
    );

    sup_back #(
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (r_base),
        .i_valid     (q_valid),
        .i_cls       (q_cls),
        .o_pop       (q_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_acc       (out_acc),
        .o_neg       (out_neg),
        .o_end       (out_end),
        .o_ovf       (out_ovf),
        .o_conv      (out_conv)
    );

    // negation done after the output register, off the multiply path
    assign out_val = out_neg ? (~out_acc + 1'b1) : out_acc;

    assign m_axis_tdata = {6'd0, out_conv, out_ovf, out_end,
                           sup_pkg::OUT_W'(out_val)};

    a_ovf_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[80] |-> m_axis_tdata[81])
        else $error("overflow without a converted digit");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[80] |-> (out_val == '1))
        else $error("overflow value not saturated");

    a_noconv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[81] |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("value nonzero with no digit taken");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

### sim/tb_string_to_unsigned_parser.sv
`timescale 1ns / 1ps

module tb_string_to_unsigned_parser;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 475;

    localparam logic [sup_pkg::CH_W-1:0] CH_LF  = 8'h0A;
    localparam logic [sup_pkg::CH_W-1:0] CH_VT  = 8'h0B;
    localparam logic [sup_pkg::CH_W-1:0] CH_FF  = 8'h0C;
    localparam logic [sup_pkg::CH_W-1:0] CH_NUL = 8'h00;
    localparam logic [sup_pkg::CH_W-1:0] CH_ANY = 8'hFF;

    // same bit order as m_axis_tdata, lowest field last
    typedef struct packed {
        logic [5:0]                pad;
        logic                      conv;
        logic                      ovf;
        logic [sup_pkg::END_W-1:0] endo;
        logic [sup_pkg::OUT_W-1:0] value;
    } t_result;

    typedef logic [sup_pkg::CH_W-1:0] t_chars [$];

    typedef struct {
        logic [sup_pkg::BASE_W-1:0] radix;
        string                      text;
        int                         patch_at;
        logic [sup_pkg::CH_W-1:0]   patch_ch;
        bit                         typed;
        t_result                    want;
    } t_parse_case;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [5:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] ch
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;        // [63:0] value, [79:64] end_offset,
                                      // [80] overflow, [81] converted

    string_to_unsigned_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_result     pending_results [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          rx_hold_req = 1'b0;

    // parser shadow state
    logic [sup_pkg::BASE_W-1:0] base_setting = sup_pkg::BASE_RESET;
    sup_pkg::t_phase            parse_phase = sup_pkg::PH_SKIP;
    logic [sup_pkg::OUT_W-1:0]  acc_value = '0;
    int                         chars_seen = 0;
    logic [sup_pkg::END_W-1:0]  consumed = '0;
    bit                         minus_sign = 1'b0;
    bit                         any_digit = 1'b0;
    bit                         saturated = 1'b0;
    logic [sup_pkg::BASE_W-1:0] radix_now = '0;

    function automatic t_result outcome(input logic [sup_pkg::OUT_W-1:0] v, input int e,
                                        input bit o, input bit c);
        t_result r;
        r.pad   = '0;
        r.conv  = c;
        r.ovf   = o;
        r.endo  = sup_pkg::END_W'(e);
        r.value = v;
        return r;
    endfunction

    function automatic logic [5:0] char_value(input logic [sup_pkg::CH_W-1:0] c);
        if (c inside {[sup_pkg::CH_ZERO:sup_pkg::CH_NINE]}) return 6'(c - sup_pkg::CH_ZERO);
        if (c inside {[sup_pkg::CH_UA:sup_pkg::CH_UZ]}) return 6'(c - sup_pkg::CH_UA + 8'd10);
        if (c inside {[sup_pkg::CH_LA:sup_pkg::CH_LZ]}) return 6'(c - sup_pkg::CH_LA + 8'd10);
        return sup_pkg::NOT_DIGIT;
    endfunction

    function automatic bit is_blank(input logic [sup_pkg::CH_W-1:0] c);
        return c inside {sup_pkg::CH_SP, sup_pkg::CH_TAB, CH_LF, CH_VT, CH_FF, sup_pkg::CH_CR};
    endfunction

    function automatic void restart_string();
        parse_phase = sup_pkg::PH_SKIP;
        acc_value   = '0;
        chars_seen  = 0;
        consumed    = '0;
        minus_sign  = 1'b0;
        any_digit   = 1'b0;
        radix_now   = '0;
        saturated   = 1'b0;
    endfunction

    function automatic void abort_string();
        acc_value   = '0;
        consumed    = '0;
        any_digit   = 1'b0;
        minus_sign  = 1'b0;
        saturated   = 1'b0;
        parse_phase = sup_pkg::PH_DONE;
    endfunction

    function automatic void take_char(input logic [sup_pkg::CH_W-1:0] c);
        logic [5:0]  dv;
        logic [70:0] wide;
        if (parse_phase == sup_pkg::PH_DONE) return;
        if (parse_phase == sup_pkg::PH_SKIP) begin
            if (is_blank(c)) begin
                consumed++;
                return;
            end
            if (c == sup_pkg::CH_PLUS || c == sup_pkg::CH_MINUS) begin
                minus_sign  = (c == sup_pkg::CH_MINUS);
                consumed++;
                parse_phase = sup_pkg::PH_SIGN;
                return;
            end
            parse_phase = sup_pkg::PH_SIGN;
        end
        if (parse_phase == sup_pkg::PH_SIGN) begin
            if (c == sup_pkg::CH_ZERO) begin
                consumed++;
                any_digit   = 1'b1;
                parse_phase = sup_pkg::PH_ZERO;
                return;
            end
            if (radix_now == sup_pkg::BASE_AUTO) radix_now = sup_pkg::BASE_DEC;
            parse_phase = sup_pkg::PH_DIGITS;
        end
        if (parse_phase == sup_pkg::PH_ZERO) begin
            if (c == sup_pkg::CH_LX || c == sup_pkg::CH_UX) begin
                if (radix_now != sup_pkg::BASE_AUTO && radix_now != sup_pkg::BASE_HEX) begin
                    abort_string();
                    return;
                end
                radix_now   = sup_pkg::BASE_HEX;
                any_digit   = 1'b0;
                consumed++;
                parse_phase = sup_pkg::PH_DIGITS;
                return;
            end
            if (radix_now == sup_pkg::BASE_AUTO) radix_now = sup_pkg::BASE_OCT;
            parse_phase = sup_pkg::PH_DIGITS;
        end
        dv = char_value(c);
        if (radix_now < 2 || dv >= radix_now) begin
            parse_phase = sup_pkg::PH_DONE;
            return;
        end
        // exact overflow test on a wide product
        wide = 71'(acc_value) * 71'(radix_now) + 71'(dv);
        if (wide[70:64] != '0) begin
            saturated   = 1'b1;
            acc_value   = '1;
            any_digit   = 1'b1;
            parse_phase = sup_pkg::PH_DONE;
            return;
        end
        acc_value = wide[63:0];
        any_digit = 1'b1;
        consumed++;
    endfunction

    function automatic bit predict_parse(input logic [sup_pkg::CH_W-1:0] c, input bit lst,
                                         output t_result r);
        r = '0;
        if (chars_seen == 0) begin
            radix_now = base_setting;
            if (base_setting == sup_pkg::BASE_ONE ||
                base_setting > sup_pkg::BASE_MAX) abort_string();
        end
        if (chars_seen < sup_pkg::MAX_LEN_DEF) begin
            chars_seen++;
            take_char(c);
        end else begin
            parse_phase = sup_pkg::PH_DONE;
        end
        if (!lst) return 1'b0;
        if (saturated) r.value = '1;
        else if (minus_sign && any_digit) r.value = -acc_value;
        else r.value = acc_value;
        r.endo = consumed;
        r.ovf  = saturated;
        r.conv = any_digit;
        restart_string();
        return 1'b1;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    task automatic send_string(input t_chars s, input bit typed, input t_result want);
        t_result predicted;
        bit      fired;
        foreach (s[i]) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= s[i];
            s_axis_tlast  <= (i == s.size() - 1);
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            fired = predict_parse(s[i], i == s.size() - 1, predicted);
            if (fired) pending_results.push_back(typed ? want : predicted);
        end
    endtask

    // sender stops until every result is back, then lets the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_base(input logic [sup_pkg::BASE_W-1:0] b);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        base_setting = b;
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_chars build_number(input logic [sup_pkg::BASE_W-1:0] b);
        t_chars                   s;
        int                       radix, ndig, d, k;
        logic [sup_pkg::CH_W-1:0] blanks [6];
        blanks = '{sup_pkg::CH_SP, sup_pkg::CH_TAB, CH_LF, CH_VT, CH_FF, sup_pkg::CH_CR};
        radix = (b == sup_pkg::BASE_AUTO) ? 10 : int'(b);
        repeat ($urandom_range(3)) s.push_back(blanks[$urandom_range(5)]);
        case ($urandom_range(3))
            0: s.push_back(sup_pkg::CH_PLUS);
            1: s.push_back(sup_pkg::CH_MINUS);
            default: ;
        endcase
        k = $urandom_range(11);
        // k == 0 puts a hex prefix under any base, which aborts unless hex or auto
        if (k < 3 && (b == sup_pkg::BASE_AUTO || b == sup_pkg::BASE_HEX || k == 0)) begin
            s.push_back(sup_pkg::CH_ZERO);
            s.push_back($urandom_range(1) ? sup_pkg::CH_LX : sup_pkg::CH_UX);
            radix = 16;
        end else if (k < 6 && b == sup_pkg::BASE_AUTO) begin
            s.push_back(sup_pkg::CH_ZERO);
            radix = 8;
        end
        if (radix < 2 || radix > 36) radix = 10;
        ndig = ($urandom_range(7) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 8);
        repeat (ndig) begin
            d = $urandom_range(radix - 1);
            if (d < 10) s.push_back(sup_pkg::CH_ZERO + 8'(d));
            else s.push_back(($urandom_range(1) ? sup_pkg::CH_UA : sup_pkg::CH_LA)
                             + 8'(d - 10));
        end
        case ($urandom_range(3))
            0: s.push_back(CH_NUL);
            1: s.push_back(8'($urandom_range(255)));
            default: ;
        endcase
        repeat ($urandom_range(2)) s.push_back(8'($urandom_range(255)));
        if (s.size() == 0) s.push_back(sup_pkg::CH_ZERO);
        return s;
    endfunction

    function automatic logic [sup_pkg::BASE_W-1:0] pick_base();
        case ($urandom_range(9))
            0, 1: return sup_pkg::BASE_AUTO;
            2: return 6'd2;
            3: return sup_pkg::BASE_MAX;
            4: return sup_pkg::BASE_HEX;
            5: return sup_pkg::BASE_OCT;
            6: return sup_pkg::BASE_DEC;
            7: return 6'($urandom_range(63));
            default: return 6'($urandom_range(2, 36));
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result value=%h end=%0d ovf=%b conv=%b",
                                     got.value, got.endo, got.ovf, got.conv));
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.endo !== want.endo ||
                    got.ovf !== want.ovf || got.conv !== want.conv ||
                    got.pad !== want.pad) begin
                    note_error($sformatf({"result differs: want value=%h end=%0d ovf=%b ",
                        "conv=%b pad=%h, got value=%h end=%0d ovf=%b conv=%b pad=%h"},
                        want.value, want.endo, want.ovf, want.conv, want.pad,
                        got.value, got.endo, got.ovf, got.conv, got.pad));
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                i_cfg_we || !i_rst_n) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_parse_case               rows [$];
        t_chars                    s;
        int                        sent, block_left;
        logic [sup_pkg::OUT_W-1:0] ones;
        ones = '1;

        rows.push_back('{sup_pkg::BASE_DEC, "0", -1, CH_NUL, 1, outcome(0, 1, 0, 1)});
        rows.push_back('{sup_pkg::BASE_DEC, " \t\n+42", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_DEC, "#-13", 0, CH_VT, 0, '0});
        rows.push_back('{sup_pkg::BASE_DEC, "#7", 0, CH_FF, 0, '0});
        rows.push_back('{sup_pkg::BASE_DEC, "#+8", 0, sup_pkg::CH_CR, 0, '0});
        rows.push_back('{sup_pkg::BASE_DEC, "-7", -1, CH_NUL, 1,
                         outcome(64'hFFFF_FFFF_FFFF_FFF9, 2, 0, 1)});
        rows.push_back('{sup_pkg::BASE_DEC, "18446744073709551615", -1, CH_NUL, 1,
                         outcome(ones, 20, 0, 1)});
        rows.push_back('{sup_pkg::BASE_DEC, "18446744073709551616", -1, CH_NUL, 1,
                         outcome(ones, 19, 1, 1)});
        rows.push_back('{sup_pkg::BASE_DEC, "-", -1, CH_NUL, 1, outcome(0, 1, 0, 0)});
        rows.push_back('{sup_pkg::BASE_DEC, "#123", 0, CH_NUL, 1, outcome(0, 0, 0, 0)});
        rows.push_back('{sup_pkg::BASE_DEC, "12#34", 2, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_DEC, "5#", 1, CH_ANY, 0, '0});
        rows.push_back('{sup_pkg::BASE_DEC, "0x12", -1, CH_NUL, 1, outcome(0, 0, 0, 0)});
        rows.push_back('{sup_pkg::BASE_ONE, "123", -1, CH_NUL, 1, outcome(0, 0, 0, 0)});
        rows.push_back('{6'd63, "5", -1, CH_NUL, 1, outcome(0, 0, 0, 0)});
        rows.push_back('{6'd37, "5", -1, CH_NUL, 1, outcome(0, 0, 0, 0)});
        rows.push_back('{sup_pkg::BASE_AUTO, "0x1fF", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_AUTO, "0X", -1, CH_NUL, 1, outcome(0, 2, 0, 0)});
        rows.push_back('{sup_pkg::BASE_AUTO, "017", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_AUTO, "0789", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_AUTO, "99", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_HEX, "0Xa", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_MAX, "Zz9", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_MAX, "zzzzzzzzzzzzz", -1, CH_NUL, 1,
                         outcome(ones, 12, 1, 1)});
        rows.push_back('{6'd2, "1012", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_DEC, "  -0", -1, CH_NUL, 0, '0});
        rows.push_back('{sup_pkg::BASE_DEC, "-18446744073709551615", -1, CH_NUL, 0, '0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        restart_string();
        @(posedge i_clk);

        // directed: first row runs on the reset base
        foreach (rows[r]) begin
            if (rows[r].radix != base_setting) set_base(rows[r].radix);
            s.delete();
            for (int i = 0; i < rows[r].text.len(); i++) s.push_back(rows[r].text[i]);
            if (rows[r].patch_at >= 0) s[rows[r].patch_at] = rows[r].patch_ch;
            send_string(s, rows[r].typed, rows[r].want);
        end

        // random: no idling, sender idle, receiver stalling, both
        for (int p = 0; p < 4; p++) begin
            settle();
            tx_idle_pct  = (p == 1) ? 68 : (p == 3) ? 10 : 0;
            rx_stall_pct = (p == 2) ? 68 : (p == 3) ? 10 : 0;
            sent = 0;
            block_left = 0;
            while (sent < PHASE_ITEMS) begin
                if (block_left <= 0) begin
                    set_base(pick_base());
                    block_left = $urandom_range(40, 90);
                end
                if (p == 0 && sent >= 200 && sent - 200 < 10) rx_hold_req = 1'b1;
                if ($urandom_range(9) < 2) begin
                    s.delete();
                    repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
                end else begin
                    s = build_number(base_setting);
                end
                send_string(s, 1'b0, '0);
                sent += s.size();
                block_left -= s.size();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        error_count += pending_results.size();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
